@@ design/mobg_pkg.sv @@
// Package with the constants, payload types and state codes of the box grouper.
package mobg_pkg;

  localparam int MAX_GROUPS = 64;
  localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
  localparam int COORD_W    = 16;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int AREA_W     = 32;
  localparam int OUT_IDX_W  = 6;

  typedef struct packed {
    logic               start_set;
    logic [COORD_W-1:0] rect_left;
    logic [COORD_W-1:0] rect_top;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
  } mobg_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] group_index;
    logic                 new_group;
    logic                 table_full;
    logic [AREA_W-1:0]    overlap_area;
  } mobg_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [EDGE_W-1:0]  right;
    logic [EDGE_W-1:0]  bottom;
  } mobg_box_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } mobg_state_e;

endpackage

@@ design/mobg_if.sv @@
// Valid/ready channel interfaces for rectangle input and grouping results.
interface mobg_in_if
  import mobg_pkg::*;
();
  logic     valid;
  logic     ready;
  mobg_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mobg_out_if
  import mobg_pkg::*;
();
  logic      valid;
  logic      ready;
  mobg_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/max_overlap_box_grouper_core.sv @@
// Top level of the box grouper: group table, scan pipeline and sequencer.
// A new rectangle is accepted only in the idle state, after the previous result is loaded.
// The single read port of the group table feeds one overlap and multiply pipeline,
// one entry per cycle. A finished result waits in an output register.
// Reset clears the state, the group count and the output valid; table contents stay.
module max_overlap_box_grouper_core
  import mobg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mobg_in_if.sink     in_i,
  mobg_out_if.source  out_o
);

  mobg_state_e state_q, state_d;

  mobg_box_t         rect_q, rect_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic [AREA_W-1:0] best_area_q, best_area_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;

  mobg_box_t         group_mem_q [MAX_GROUPS];
  mobg_box_t         rdata_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  rd_addr;

  logic              issue;
  logic              v1_q, v2_q, v3_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q, idx3_q;
  logic [COORD_W-1:0] w_q, h_q;
  logic [AREA_W-1:0] area_q;

  logic [EDGE_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [COORD_W-1:0] w_d, h_d;

  logic              found;
  logic              full;
  logic              out_load;
  logic              out_valid_q;
  mobg_out_t         out_data_q, out_data_d;

  assign found   = (best_area_q != '0);
  assign full    = (count_q == CNT_W'(MAX_GROUPS));
  assign rd_addr = scan_idx_q[IDX_W-1:0];

  assign lo_x = (EDGE_W'(rdata_q.left) > EDGE_W'(rect_q.left)) ?
                EDGE_W'(rdata_q.left) : EDGE_W'(rect_q.left);
  assign hi_x = (rdata_q.right < rect_q.right) ? rdata_q.right : rect_q.right;
  assign lo_y = (EDGE_W'(rdata_q.top) > EDGE_W'(rect_q.top)) ?
                EDGE_W'(rdata_q.top) : EDGE_W'(rect_q.top);
  assign hi_y = (rdata_q.bottom < rect_q.bottom) ? rdata_q.bottom : rect_q.bottom;
  assign w_d  = (hi_x > lo_x) ? COORD_W'(hi_x - lo_x) : '0;
  assign h_d  = (hi_y > lo_y) ? COORD_W'(hi_y - lo_y) : '0;

  always_comb begin
    state_d     = state_q;
    rect_d      = rect_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    best_area_d = best_area_q;
    best_idx_d  = best_idx_q;
    issue       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = count_q[IDX_W-1:0];
    out_load    = 1'b0;
    out_data_d  = out_data_q;
    in_i.ready  = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rect_d.left   = in_i.data.rect_left;
          rect_d.top    = in_i.data.rect_top;
          rect_d.right  = EDGE_W'(in_i.data.rect_left) + EDGE_W'(in_i.data.rect_width);
          rect_d.bottom = EDGE_W'(in_i.data.rect_top) + EDGE_W'(in_i.data.rect_height);
          if (in_i.data.start_set) begin
            count_d = '0;
          end
          scan_idx_d  = '0;
          best_area_d = '0;
          best_idx_d  = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_idx_q < count_q) begin
          issue      = 1'b1;
          scan_idx_d = scan_idx_q + CNT_W'(1);
        end else if (!v1_q && !v2_q && !v3_q) begin
          state_d = S_DONE;
        end
        if (v3_q && (area_q > best_area_q)) begin
          best_area_d = area_q;
          best_idx_d  = idx3_q;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (found) begin
            mem_we     = 1'b1;
            mem_waddr  = best_idx_q;
            out_data_d = '{group_index:  OUT_IDX_W'(best_idx_q),
                           new_group:    1'b0,
                           table_full:   1'b0,
                           overlap_area: best_area_q};
          end else if (!full) begin
            mem_we     = 1'b1;
            count_d    = count_q + CNT_W'(1);
            out_data_d = '{group_index:  OUT_IDX_W'(count_q),
                           new_group:    1'b1,
                           table_full:   1'b0,
                           overlap_area: '0};
          end else begin
            out_data_d = '{group_index:  '0,
                           new_group:    1'b0,
                           table_full:   1'b1,
                           overlap_area: '0};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_idx_q <= scan_idx_d;
      v1_q       <= issue;
      v2_q       <= v1_q;
      v3_q       <= v2_q;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q      <= rect_d;
    best_area_q <= best_area_d;
    best_idx_q  <= best_idx_d;
    idx1_q      <= rd_addr;
    idx2_q      <= idx1_q;
    idx3_q      <= idx2_q;
    w_q         <= w_d;
    h_q         <= h_d;
    area_q      <= AREA_W'(w_q) * AREA_W'(h_q);
    out_data_q  <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      group_mem_q[mem_waddr] <= rect_q;
    end
    rdata_q <= group_mem_q[rd_addr];
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

@@ design/mobg_checker.sv @@
// Port-level assertions for the box grouper and the bind that attaches them.
module mobg_checker
  import mobg_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input mobg_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("Stalled result transaction changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Input accepted again while a rectangle is in work.");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.table_full |->
      !out_data_i.new_group && (out_data_i.overlap_area == '0) &&
      (out_data_i.group_index == '0))
    else $error("Full-table result carries an index, area or new-group mark.");

  a_new_group_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.new_group |->
      (out_data_i.overlap_area == '0) && !out_data_i.table_full)
    else $error("New-group result carries an overlap area or full flag.");

endmodule

bind max_overlap_box_grouper_core mobg_checker u_mobg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

@@ bench/mobg_group_checker.sv @@
// Checker that predicts the group assignment of each rectangle and compares the DUT results.
`timescale 1ns / 1ps

module mobg_group_checker
  import mobg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mobg_in_if   rect_i,
  mobg_out_if  result_i,
  output int   error_count_o,
  output int   pending_o,
  output int   new_count_o,
  output int   replace_count_o,
  output int   full_count_o
);

  mobg_box_t   group_boxes [MAX_GROUPS];
  int unsigned group_total;
  mobg_out_t   expected_groups [$];

  function automatic longint unsigned span_overlap(input longint unsigned lo_a,
                                                   input longint unsigned hi_a,
                                                   input longint unsigned lo_b,
                                                   input longint unsigned hi_b);
    longint unsigned lo;
    longint unsigned hi;
    lo = (lo_a > lo_b) ? lo_a : lo_b;
    hi = (hi_a < hi_b) ? hi_a : hi_b;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic mobg_out_t assign_group(input mobg_in_t rect);
    mobg_box_t       box;
    mobg_out_t       res;
    longint unsigned area;
    longint unsigned best_area;
    int              best;
    box.left   = rect.rect_left;
    box.top    = rect.rect_top;
    box.right  = EDGE_W'(rect.rect_left) + EDGE_W'(rect.rect_width);
    box.bottom = EDGE_W'(rect.rect_top) + EDGE_W'(rect.rect_height);
    if (rect.start_set) group_total = 0;
    best      = -1;
    best_area = 0;
    for (int i = 0; i < group_total; i++) begin
      area = span_overlap(group_boxes[i].left, group_boxes[i].right, box.left, box.right) *
             span_overlap(group_boxes[i].top, group_boxes[i].bottom, box.top, box.bottom);
      if (area > best_area) begin
        best_area = area;
        best      = i;
      end
    end
    res = '0;
    if (best >= 0) begin
      group_boxes[best] = box;
      res.group_index   = OUT_IDX_W'(best);
      res.overlap_area  = (best_area > 64'hFFFF_FFFF) ? '1 : best_area[AREA_W-1:0];
      replace_count_o++;
    end else if (group_total < MAX_GROUPS) begin
      group_boxes[group_total] = box;
      res.group_index = OUT_IDX_W'(group_total);
      res.new_group   = 1'b1;
      group_total++;
      new_count_o++;
    end else begin
      res.table_full = 1'b1;
      full_count_o++;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mobg_out_t want;
    mobg_out_t got;
    if (!rst_ni) begin
      expected_groups.delete();
      group_total     = 0;
      error_count_o   = 0;
      pending_o       = 0;
      new_count_o     = 0;
      replace_count_o = 0;
      full_count_o    = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        got = result_i.data;
        if (expected_groups.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %p",
                   $time, got);
          error_count_o++;
        end else begin
          want = expected_groups.pop_front();
          if (got.group_index !== want.group_index) begin
            $display("%0t: group_index mismatch, expected %0d, actual %0d",
                     $time, want.group_index, got.group_index);
            error_count_o++;
          end
          if (got.new_group !== want.new_group) begin
            $display("%0t: new_group mismatch, expected %0b, actual %0b",
                     $time, want.new_group, got.new_group);
            error_count_o++;
          end
          if (got.table_full !== want.table_full) begin
            $display("%0t: table_full mismatch, expected %0b, actual %0b",
                     $time, want.table_full, got.table_full);
            error_count_o++;
          end
          if (got.overlap_area !== want.overlap_area) begin
            $display("%0t: overlap_area mismatch, expected %0d, actual %0d",
                     $time, want.overlap_area, got.overlap_area);
            error_count_o++;
          end
        end
      end
      if (rect_i.valid && rect_i.ready) begin
        expected_groups = {expected_groups, assign_group(rect_i.data)};
      end
      pending_o = expected_groups.size();
    end
  end

endmodule

@@ bench/max_overlap_box_grouper_core_tb.sv @@
// Testbench top for the box grouper: clock, reset, rectangle stimulus and verdict.
`timescale 1ns / 1ps

module max_overlap_box_grouper_core_tb;
  import mobg_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 100;
  localparam int TAIL_CYCLES  = 80;
  localparam int GRID_PITCH   = 1000;

  logic clk_i;
  logic rst_ni;

  mobg_in_if  rect_ch ();
  mobg_out_if result_ch ();

  int error_count;
  int pending;
  int new_count;
  int replace_count;
  int full_count;

  int       send_idle_pct;
  int       recv_stall_pct;
  logic     hold_req;
  int       items_sent;
  int       idle_cycles = 0;
  mobg_in_t slice_hist [$];

  max_overlap_box_grouper_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (rect_ch),
    .out_o  (result_ch)
  );

  mobg_group_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rect_i          (rect_ch),
    .result_i        (result_ch),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .new_count_o     (new_count),
    .replace_count_o (replace_count),
    .full_count_o    (full_count)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((rect_ch.valid && rect_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int hold_cnt;
    hold_cnt = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_cnt < LONG_HOLD) begin
        result_ch.ready <= 1'b0;
        hold_cnt++;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic mobg_in_t mk_rect(input int s, input int l, input int t,
                                       input int w, input int h);
    mobg_in_t r;
    r.start_set   = 1'(s);
    r.rect_left   = 16'(l);
    r.rect_top    = 16'(t);
    r.rect_width  = 16'(w);
    r.rect_height = 16'(h);
    return r;
  endfunction

  function automatic int nudge(input int v);
    int n;
    n = v + int'($urandom_range(60)) - 30;
    if (n < 0) n = 0;
    if (n > 65535) n = 65535;
    return n;
  endfunction

  task automatic send_rect(input mobg_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      rect_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rect_ch.valid <= 1'b1;
    rect_ch.data  <= r;
    @(posedge clk_i);
    while (!rect_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic await_results();
    rect_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_rect(mk_rect(1, 0, 0, 0, 0));
    send_rect(mk_rect(0, 0, 0, 65535, 65535));
    send_rect(mk_rect(0, 65535, 65535, 65535, 65535));
    send_rect(mk_rect(0, 100, 100, 10, 10));
    send_rect(mk_rect(0, 100, 100, 10, 10));
    send_rect(mk_rect(0, 105, 100, 10, 10));
    send_rect(mk_rect(0, 115, 100, 10, 10));
    send_rect(mk_rect(0, 10, 10, 50, 0));
    send_rect(mk_rect(1, 0, 0, 10, 10));
    send_rect(mk_rect(0, 20, 0, 10, 10));
    send_rect(mk_rect(0, 5, 0, 20, 10));
    send_rect(mk_rect(0, 19, 0, 11, 10));
    send_rect(mk_rect(1, 0, 0, 65535, 65535));
    send_rect(mk_rect(0, 0, 0, 65535, 65535));
    send_rect(mk_rect(1, 65535, 0, 65535, 1));
    send_rect(mk_rect(0, 65535, 0, 1, 1));
    send_rect(mk_rect(1, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
    send_rect(mk_rect(0, 'h5555, 'hAAAA, 'h5555, 'hAAAA));
  endtask

  // Disjoint rectangles in an 8 by 8 grid fill the table; the extra row then finds it full.
  task automatic run_table_fill();
    mobg_in_t r;
    int       slot;
    for (int k = 0; k < 68; k++) begin
      r = mk_rect(int'(k == 0), (k % 8) * GRID_PITCH + $urandom_range(400),
                  (k / 8) * GRID_PITCH + $urandom_range(400),
                  $urandom_range(1, 500), $urandom_range(1, 500));
      if (k == 66) r.rect_width = 16'd0;
      send_rect(r);
    end
    slot = $urandom_range(63);
    send_rect(mk_rect(0, (slot % 8) * GRID_PITCH, (slot / 8) * GRID_PITCH, 900, 900));
  endtask

  task automatic run_slice_stack(input int n);
    mobg_in_t r;
    mobg_in_t prev;
    int       pick;
    slice_hist.delete();
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      prev = (slice_hist.size() > 0) ? slice_hist[$urandom_range(slice_hist.size() - 1)]
                                     : mk_rect(0, 0, 0, 0, 0);
      if (pick < 50 && slice_hist.size() > 0) begin
        r = mk_rect(0, nudge(int'(prev.rect_left)), nudge(int'(prev.rect_top)),
                    nudge(int'(prev.rect_width)), nudge(int'(prev.rect_height)));
      end else if (pick < 75) begin
        r = mk_rect(0, $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(1, 2000), $urandom_range(1, 2000));
      end else if (pick < 85) begin
        {r.rect_left, r.rect_top}    = $urandom();
        {r.rect_width, r.rect_height} = $urandom();
      end else if (pick < 95) begin
        r = mk_rect(0, 65535 - $urandom_range(50), 65535 - $urandom_range(50),
                    ($urandom_range(1) == 1) ? 65535 : 0,
                    ($urandom_range(3) == 0) ? 0 : $urandom_range(65535));
      end else begin
        r = prev;
      end
      r.start_set = (pick >= 75 && pick < 85) ? 1'($urandom_range(1)) : (k == 0);
      slice_hist = {slice_hist, r};
      send_rect(r);
    end
  endtask

  initial begin
    int start_items;
    rst_ni          = 1'b0;
    rect_ch.valid   = 1'b0;
    rect_ch.data    = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    items_sent      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    await_results();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      start_items = items_sent;
      if (phase == 0 || phase == 2) run_table_fill();
      while (items_sent - start_items < PHASE_ITEMS) run_slice_stack($urandom_range(5, 30));
      await_results();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d rectangles over four pacing phases, one with a long output hold.",
             items_sent);
    $display("Predicted %0d new groups, %0d replacements and %0d full-table results.",
             new_count, replace_count, full_count);
    if (error_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ max_overlap_box_grouper_core.f @@
design/mobg_pkg.sv
design/mobg_if.sv
design/max_overlap_box_grouper_core.sv
design/mobg_checker.sv
bench/mobg_group_checker.sv
bench/max_overlap_box_grouper_core_tb.sv
